// File: sv/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg
// Shared types and constants of the block deframer with CRC-32 check.
// ----------------------------------------------------------------------------
package bdc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  // Depth of the command queue between front and back
  localparam int CMD_DEPTH = 4;
  localparam int CMD_AW    = $clog2(CMD_DEPTH);
  localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);

  typedef enum logic [2:0] {
    PH_NAME  = 3'd0,
    PH_MAX   = 3'd1,
    PH_BNUM  = 3'd2,
    PH_BSIZE = 3'd3,
    PH_DATA  = 3'd4,
    PH_CRC   = 3'd5,
    PH_DONE  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NAME    = 2'd0,
    KIND_DATA    = 2'd1,
    KIND_VERDICT = 2'd2,
    KIND_END     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    VERD_OK       = 2'd0,
    VERD_CRC_ERR  = 2'd1,
    VERD_OVERSIZE = 2'd2
  } verdict_t;

  // Command from the parser to the checker
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        first;
    logic        oversize;
    logic [31:0] index;
    logic [31:0] length;
    logic [31:0] rx_crc;
  } cmd_t;

  // Finished result word
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    logic [31:0] index;
    logic [31:0] length;
    verdict_t    verdict;
    logic [31:0] crc;
  } res_t;

  // One reflected CRC-32 byte update, eight shift steps
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/bdc_front.sv
// ----------------------------------------------------------------------------
// bdc_front
// Stream parser: walks header, block fields and data, and issues one
// command word for each byte that causes a result.
// ----------------------------------------------------------------------------
module bdc_front #(
  parameter int NAME_BYTES = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  output logic          cmd_wr,
  output bdc_pkg::cmd_t cmd
);
  import bdc_pkg::*;

  localparam logic [31:0] NAME_LAST = 32'(NAME_BYTES - 1);

  phase_t      phase_r, phase_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] max_r, max_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] rxcrc_r, rxcrc_nxt;
  logic        last4;
  logic [32:0] count_inc;

  assign last4     = (count_r == 32'd3);
  assign count_inc = {1'b0, count_r} + 33'd1;

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NAME;
      count_r <= '0;
      max_r   <= '0;
      idx_r   <= '0;
      len_r   <= '0;
      rxcrc_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      max_r   <= max_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      rxcrc_r <= rxcrc_nxt;
    end
  end

  // Advance through the stream and classify each byte
  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    max_nxt      = max_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    rxcrc_nxt    = rxcrc_r;
    cmd_wr       = 1'b0;
    cmd.kind     = KIND_NAME;
    cmd.data     = rx_byte;
    cmd.first    = 1'b0;
    cmd.oversize = 1'b0;
    cmd.index    = idx_r;
    cmd.length   = len_r;
    cmd.rx_crc   = rxcrc_r;
    if (accept) begin
      case (phase_r)
        PH_NAME: begin
          cmd_wr   = 1'b1;
          cmd.kind = KIND_NAME;
          if (count_r == NAME_LAST) begin
            count_nxt = '0;
            phase_nxt = PH_MAX;
          end else begin
            count_nxt = count_inc[31:0];
          end
        end
        PH_MAX: begin
          max_nxt = {rx_byte, max_r[31:8]};
          if (last4) begin
            count_nxt = '0;
            phase_nxt = PH_BNUM;
          end else begin
            count_nxt = count_inc[31:0];
          end
        end
        PH_BNUM: begin
          idx_nxt = {rx_byte, idx_r[31:8]};
          if (last4) begin
            count_nxt = '0;
            phase_nxt = PH_BSIZE;
          end else begin
            count_nxt = count_inc[31:0];
          end
        end
        PH_BSIZE: begin
          len_nxt = {rx_byte, len_r[31:8]};
          if (last4) begin
            count_nxt = '0;
            if (len_nxt == 32'd0) begin
              phase_nxt  = PH_DONE;
              cmd_wr     = 1'b1;
              cmd.kind   = KIND_END;
              cmd.length = '0;
            end else begin
              phase_nxt = PH_DATA;
            end
          end else begin
            count_nxt = count_inc[31:0];
          end
        end
        PH_DATA: begin
          cmd_wr    = 1'b1;
          cmd.kind  = KIND_DATA;
          cmd.first = (count_r == 32'd0);
          if (count_inc >= {1'b0, len_r}) begin
            count_nxt = '0;
            phase_nxt = PH_CRC;
          end else begin
            count_nxt = count_inc[31:0];
          end
        end
        PH_CRC: begin
          rxcrc_nxt = {rx_byte, rxcrc_r[31:8]};
          if (last4) begin
            count_nxt    = '0;
            phase_nxt    = PH_BNUM;
            cmd_wr       = 1'b1;
            cmd.kind     = KIND_VERDICT;
            cmd.oversize = (len_r > max_r);
            cmd.rx_crc   = rxcrc_nxt;
          end else begin
            count_nxt = count_inc[31:0];
          end
        end
        default: begin
          // ended: drop every byte
        end
      endcase
    end
  end

endmodule

// File: sv/bdc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// bdc_cmd_fifo
// Short command queue that decouples the parser from the checker.
// ----------------------------------------------------------------------------
module bdc_cmd_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr,
  input  bdc_pkg::cmd_t             wr_data,
  input  logic                      rd,
  output bdc_pkg::cmd_t             rd_data,
  output logic                      full,
  output logic                      empty,
  output logic [bdc_pkg::CMD_CW-1:0] count
);
  import bdc_pkg::*;

  cmd_t              mem_r [CMD_DEPTH];
  logic [CMD_AW-1:0] wp_r, wp_nxt;
  logic [CMD_AW-1:0] rp_r, rp_nxt;
  logic [CMD_CW-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full    = (cnt_r == CMD_CW'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rd_data = mem_r[rp_r];
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;

  // Advance pointers and fill count
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == CMD_AW'(CMD_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == CMD_AW'(CMD_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// File: sv/bdc_back.sv
// ----------------------------------------------------------------------------
// bdc_back
// Checker: runs the CRC over data commands, forms verdicts and holds the
// finished result word in the output register.
// ----------------------------------------------------------------------------
module bdc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  bdc_pkg::cmd_t cmd,
  input  logic          cmd_avail,
  output logic          cmd_rd,
  input  logic          res_pop,
  output logic          res_valid,
  output bdc_pkg::res_t res
);
  import bdc_pkg::*;

  logic [31:0] crc_r, crc_nxt;
  logic        valid_r, valid_nxt;
  res_t        res_r, res_nxt;
  logic [31:0] fin;

  assign cmd_rd    = cmd_avail && (!valid_r || res_pop);
  assign res_valid = valid_r;
  assign res       = res_r;
  assign fin       = ~crc_r;

  // Execute one command into the output register
  always_comb begin
    crc_nxt         = crc_r;
    res_nxt         = res_r;
    valid_nxt       = valid_r && !res_pop;
    if (cmd_rd) begin
      valid_nxt       = 1'b1;
      res_nxt.kind    = cmd.kind;
      res_nxt.payload = 8'd0;
      res_nxt.index   = cmd.index;
      res_nxt.length  = cmd.length;
      res_nxt.verdict = VERD_OK;
      res_nxt.crc     = '0;
      case (cmd.kind)
        KIND_NAME: begin
          res_nxt.payload = cmd.data;
        end
        KIND_DATA: begin
          res_nxt.payload = cmd.data;
          crc_nxt = crc_byte(cmd.first ? CRC_INIT : crc_r, cmd.data);
        end
        KIND_VERDICT: begin
          res_nxt.crc = fin;
          if (cmd.oversize) begin
            res_nxt.verdict = VERD_OVERSIZE;
          end else if (fin == cmd.rx_crc) begin
            res_nxt.verdict = VERD_OK;
          end else begin
            res_nxt.verdict = VERD_CRC_ERR;
          end
        end
        default: begin
          // end of transfer carries only the block number
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      crc_r   <= CRC_INIT;
    end else begin
      valid_r <= valid_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

// File: sv/block_deframer_crc32_check_unit.sv
// ----------------------------------------------------------------------------
// block_deframer_crc32_check_unit
// Receive deframer: forwards name and block data bytes, checks each block
// with a reflected CRC-32 and reports a verdict per block.
// ----------------------------------------------------------------------------
// The unit takes one byte per clock and gives at most one result word per
// byte, so it sustains one byte per cycle as long as results are popped. A
// byte is parsed in its accept cycle, passes a four-word command queue and is
// finished by the CRC stage into the output register, which drives the out_
// ports. in_full rises only when the command queue is full, which happens
// after five results wait unpopped: one in the output register and four in
// the queue. The CRC update of one byte per cycle sets the rate.
module block_deframer_crc32_check_unit #(
  parameter int NAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_rx_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_item_kind,
  output logic [7:0]  out_payload_byte,
  output logic [31:0] out_block_index,
  output logic [31:0] out_block_length,
  output logic [1:0]  out_verdict,
  output logic [31:0] out_computed_crc
);
  import bdc_pkg::*;

  logic              accept;
  logic              cmd_wr;
  cmd_t              cmd_in;
  cmd_t              cmd_out;
  logic              q_full, q_empty;
  logic [CMD_CW-1:0] q_count;
  logic              cmd_rd;
  logic              res_valid;
  res_t              res;

  assign accept = in_push && !q_full;
  assign in_full = q_full;

  // Parse incoming bytes
  bdc_front #(.NAME_BYTES(NAME_BYTES)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .rx_byte (in_rx_byte),
    .cmd_wr  (cmd_wr),
    .cmd     (cmd_in)
  );

  // Queue commands
  bdc_cmd_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (cmd_wr),
    .wr_data (cmd_in),
    .rd      (cmd_rd),
    .rd_data (cmd_out),
    .full    (q_full),
    .empty   (q_empty),
    .count   (q_count)
  );

  // Check and emit results
  bdc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_out),
    .cmd_avail (!q_empty),
    .cmd_rd    (cmd_rd),
    .res_pop   (out_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_empty        = !res_valid;
  assign out_item_kind    = res.kind;
  assign out_payload_byte = res.payload;
  assign out_block_index  = res.index;
  assign out_block_length = res.length;
  assign out_verdict      = res.verdict;
  assign out_computed_crc = res.crc;

  // Queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CMD_CW'(CMD_DEPTH))
    else $error("command queue count beyond depth");

  // Checker never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !out_pop) |-> !cmd_rd)
    else $error("result overwritten before pop");

  // Only verdict words carry a verdict or a CRC
  a_verdict_only: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.kind != KIND_VERDICT) |-> (res.verdict == VERD_OK && res.crc == 32'd0))
    else $error("verdict fields set on non-verdict word");

  // Bytes accepted with a free queue always land
  a_cmd_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_wr && !cmd_rd) |=> (q_count == $past(q_count) + 1'b1))
    else $error("command word lost");

endmodule
